@@ src/qwt_pkg.sv @@
// qwt_pkg: shared types and constants for the quoted word tokenizer.
// No dependencies; used by every module of the block.

package qwt_pkg;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    localparam int MAX_RESULTS = 3;

    // configuration register indexes (paddr[4:3])
    localparam logic [1:0] REG_MASK_LOW  = 2'd0;
    localparam logic [1:0] REG_MASK_HIGH = 2'd1;
    localparam logic [1:0] REG_MAX_CHARS = 2'd2;

    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_END   = 2'd1,
        KIND_TOKEN = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_WORD   = 3'b010,
        MODE_QUOTED = 3'b100
    } mode_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] chr;
        logic       trunc;
    } result_t;

    // all results caused by one input item; count is 1..3 when queued
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [1:0]                count;
    } bundle_t;

    typedef struct packed {
        logic [63:0] mask_low;
        logic [63:0] mask_high;
        logic [7:0]  max_chars;
    } cfg_t;

endpackage

@@ src/quoted_word_tokenizer_core.sv @@
// quoted_word_tokenizer_core: top level with configuration registers, front
// scanner, bundle queue and output serializer. Depends on qwt_pkg and submodules.
//
//  channel  | signals                          | request
//  ---------+----------------------------------+--------------------------------------
//  s_       | tdata[7:0]=in_byte, tlast=line_end | one input character
//  m_       | tdata[7:0]=out_byte, [8]=truncated; tuser=kind; tlast=last_of_run
//  apb      | paddr 8*i, 64-bit pwdata/prdata  | register write / read
//
// Each input byte is scanned in the cycle it is accepted: one byte per cycle while the queue is not full.
// A byte yields zero to three results; results leave at one per cycle while m_tready is
// high, so the output serializer sets the rate when bytes yield more than one result.
// The queue holds QUEUE_DEPTH bundles; s_tready drops only when it is full.
// Reset (rst_n, async) clears scanner state, queue pointers and registers.

module quoted_word_tokenizer_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [8] truncated, rest zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,   // last_of_run
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    qwt_pkg::cfg_t    cfg_reg;
    qwt_pkg::bundle_t push_data, head;
    logic             q_push, q_pop, q_full, q_empty;
    logic             wr_en;
    logic [1:0]       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mask_low  <= 64'd0;
            cfg_reg.mask_high <= 64'd0;
            cfg_reg.max_chars <= 8'd255;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                qwt_pkg::REG_MASK_LOW:  cfg_reg.mask_low  <= pwdata;
                qwt_pkg::REG_MASK_HIGH: cfg_reg.mask_high <= pwdata;
                qwt_pkg::REG_MAX_CHARS: cfg_reg.max_chars <= pwdata[7:0];
                default:                cfg_reg.max_chars <= cfg_reg.max_chars;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            qwt_pkg::REG_MASK_LOW:  prdata = cfg_reg.mask_low;
            qwt_pkg::REG_MASK_HIGH: prdata = cfg_reg.mask_high;
            qwt_pkg::REG_MAX_CHARS: prdata = {56'd0, cfg_reg.max_chars};
            default:                prdata = 64'd0;
        endcase
    end

    qwt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .line_end (s_tlast),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (push_data)
    );

    qwt_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (head),
        .empty     (q_empty)
    );

    qwt_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ src/qwt_front.sv @@
// qwt_front: accepts input bytes, runs the word scanner state and builds the
// result bundle of each byte. Depends on qwt_pkg.

module qwt_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    input  logic            line_end,
    input  qwt_pkg::cfg_t   cfg,
    input  logic            q_full,
    output logic            q_push,
    output qwt_pkg::bundle_t q_data
);

    qwt_pkg::mode_t mode_reg, mode_next;
    logic           bs_reg, bs_next;
    logic [7:0]     len_reg, len_next;
    logic           ovf_reg, ovf_next;

    qwt_pkg::bundle_t bundle_c;
    logic [1:0]       n_c;
    logic             line_over;
    logic             in_word;
    logic             is_space;
    logic             is_token;
    logic             accept;

    assign line_over = line_end || (in_byte == 8'h00);
    assign in_word   = (mode_reg == qwt_pkg::MODE_WORD) || (mode_reg == qwt_pkg::MODE_QUOTED);
    assign is_space  = (in_byte == qwt_pkg::CH_SPACE) || (in_byte == qwt_pkg::CH_TAB) ||
                       (in_byte == qwt_pkg::CH_NEWLINE);
    assign is_token  = in_byte[7] ? 1'b0 :
                       in_byte[6] ? cfg.mask_high[in_byte[5:0]] : cfg.mask_low[in_byte[5:0]];

    always_comb
    begin
        mode_next = mode_reg;
        bs_next   = bs_reg;
        len_next  = len_reg;
        ovf_next  = ovf_reg;
        bundle_c  = '0;
        n_c       = 2'd0;

        if (line_over)
        begin
            if (in_word)
            begin
                if (bs_reg)
                begin
                    if (len_next < cfg.max_chars)
                    begin
                        bundle_c.res[n_c] = '{kind: qwt_pkg::KIND_CHAR,
                                              chr: qwt_pkg::CH_BACKSLASH, trunc: 1'b0};
                        n_c      = n_c + 2'd1;
                        len_next = len_next + 8'd1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                bundle_c.res[n_c] = '{kind: qwt_pkg::KIND_END, chr: 8'h00, trunc: ovf_next};
                n_c = n_c + 2'd1;
            end
            mode_next = qwt_pkg::MODE_IDLE;
            bs_next   = 1'b0;
            len_next  = 8'd0;
            ovf_next  = 1'b0;
        end
        else if (in_word && bs_reg && (in_byte == qwt_pkg::CH_QUOTE))
        begin
            // escaped quote: literal quote, byte consumed
            bs_next = 1'b0;
            if (len_next < cfg.max_chars)
            begin
                bundle_c.res[n_c] = '{kind: qwt_pkg::KIND_CHAR,
                                      chr: qwt_pkg::CH_QUOTE, trunc: 1'b0};
                n_c      = n_c + 2'd1;
                len_next = len_next + 8'd1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        else
        begin
            if (in_word && bs_reg)
            begin
                // held backslash was not an escape: emit it, then the byte
                bs_next = 1'b0;
                if (len_next < cfg.max_chars)
                begin
                    bundle_c.res[n_c] = '{kind: qwt_pkg::KIND_CHAR,
                                          chr: qwt_pkg::CH_BACKSLASH, trunc: 1'b0};
                    n_c      = n_c + 2'd1;
                    len_next = len_next + 8'd1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end

            case (mode_reg)
                qwt_pkg::MODE_WORD:
                begin
                    if (is_space || is_token)
                    begin
                        bundle_c.res[n_c] = '{kind: qwt_pkg::KIND_END, chr: 8'h00,
                                              trunc: ovf_next};
                        n_c       = n_c + 2'd1;
                        mode_next = qwt_pkg::MODE_IDLE;
                        bs_next   = 1'b0;
                        len_next  = 8'd0;
                        ovf_next  = 1'b0;
                        if (is_token && !is_space)
                        begin
                            bundle_c.res[n_c] = '{kind: qwt_pkg::KIND_TOKEN, chr: in_byte,
                                                  trunc: 1'b0};
                            n_c = n_c + 2'd1;
                        end
                    end
                    else if (in_byte == qwt_pkg::CH_BACKSLASH)
                    begin
                        bs_next = 1'b1;
                    end
                    else if (len_next < cfg.max_chars)
                    begin
                        bundle_c.res[n_c] = '{kind: qwt_pkg::KIND_CHAR, chr: in_byte,
                                              trunc: 1'b0};
                        n_c      = n_c + 2'd1;
                        len_next = len_next + 8'd1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                qwt_pkg::MODE_QUOTED:
                begin
                    if (in_byte == qwt_pkg::CH_QUOTE)
                    begin
                        bundle_c.res[n_c] = '{kind: qwt_pkg::KIND_END, chr: 8'h00,
                                              trunc: ovf_next};
                        n_c       = n_c + 2'd1;
                        mode_next = qwt_pkg::MODE_IDLE;
                        bs_next   = 1'b0;
                        len_next  = 8'd0;
                        ovf_next  = 1'b0;
                    end
                    else if (in_byte == qwt_pkg::CH_BACKSLASH)
                    begin
                        bs_next = 1'b1;
                    end
                    else if (len_next < cfg.max_chars)
                    begin
                        bundle_c.res[n_c] = '{kind: qwt_pkg::KIND_CHAR, chr: in_byte,
                                              trunc: 1'b0};
                        n_c      = n_c + 2'd1;
                        len_next = len_next + 8'd1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                default:
                begin
                    // between words: start from a clean word state
                    mode_next = qwt_pkg::MODE_IDLE;
                    bs_next   = 1'b0;
                    len_next  = 8'd0;
                    ovf_next  = 1'b0;
                    if (is_space)
                    begin
                        mode_next = qwt_pkg::MODE_IDLE;
                    end
                    else if (is_token)
                    begin
                        bundle_c.res[n_c] = '{kind: qwt_pkg::KIND_TOKEN, chr: in_byte,
                                              trunc: 1'b0};
                        n_c = n_c + 2'd1;
                    end
                    else if (in_byte == qwt_pkg::CH_QUOTE)
                    begin
                        mode_next = qwt_pkg::MODE_QUOTED;
                    end
                    else
                    begin
                        mode_next = qwt_pkg::MODE_WORD;
                        if (in_byte == qwt_pkg::CH_BACKSLASH)
                        begin
                            bs_next = 1'b1;
                        end
                        else if (len_next < cfg.max_chars)
                        begin
                            bundle_c.res[n_c] = '{kind: qwt_pkg::KIND_CHAR, chr: in_byte,
                                                  trunc: 1'b0};
                            n_c      = n_c + 2'd1;
                            len_next = len_next + 8'd1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                end
            endcase
        end
        bundle_c.count = n_c;
    end

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && (n_c != 2'd0);
    assign q_data   = bundle_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= qwt_pkg::MODE_IDLE;
            bs_reg   <= 1'b0;
            len_reg  <= 8'd0;
            ovf_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            bs_reg   <= bs_next;
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

@@ src/qwt_fifo.sv @@
// qwt_fifo: short queue of result bundles between front and back.
// Depends on qwt_pkg for the bundle type.

module qwt_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  qwt_pkg::bundle_t push_data,
    output logic             full,
    input  logic             pop,
    output qwt_pkg::bundle_t pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    qwt_pkg::bundle_t mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == FULL_CNT);
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

@@ src/qwt_back.sv @@
// qwt_back: walks the results of the bundle at the queue head, one per cycle while m_tready
// is high, onto the output stream. Depends on qwt_pkg.

module qwt_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  qwt_pkg::bundle_t head,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);

    logic [1:0]        idx_reg;
    qwt_pkg::result_t  cur;
    logic              last;
    logic              fire;

    assign cur      = head.res[idx_reg];
    assign last     = (idx_reg == (head.count - 2'd1));
    assign m_tvalid = !q_empty;
    assign fire     = m_tvalid && m_tready;
    assign q_pop    = fire && last;

    assign m_tdata  = {7'b0, cur.trunc, cur.chr};
    assign m_tuser  = cur.kind;
    assign m_tlast  = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else if (fire)
        begin
            idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
        end
    end

endmodule

@@ src/qwt_checker.sv @@
// qwt_checker: port-level assertions on the tokenizer output stream, and the
// bind that attaches them to quoted_word_tokenizer_core. Depends on qwt_pkg.

module qwt_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result keeps its request valid
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // word end carries no character
    a_end_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == qwt_pkg::KIND_END) |-> (m_tdata[7:0] == 8'h00))
        else $error("word end with nonzero character");

    // only word ends carry the truncation flag; token words close their run
    a_trunc_only_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != qwt_pkg::KIND_END) |-> !m_tdata[8])
        else $error("truncation flag on a non-end result");

    a_token_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == qwt_pkg::KIND_TOKEN) |-> m_tlast)
        else $error("token word not last of its run");

endmodule

bind quoted_word_tokenizer_core qwt_checker u_qwt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ test/quoted_word_tokenizer_core_tb.sv @@
// Testbench for quoted_word_tokenizer_core: directed table, then random lines under
// several token sets, word limits and handshake pressure patterns.
// Depends on qwt_pkg and the core RTL; results are checked against an in-bench predictor or the table's typed results.
`timescale 1ns / 1ps

module quoted_word_tokenizer_core_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 65;

    typedef enum logic [1:0] {
        SCAN_GAP    = 2'd0,
        SCAN_WORD   = 2'd1,
        SCAN_QUOTED = 2'd2
    } scan_t;

    typedef struct packed {
        qwt_pkg::kind_t kind;
        logic [7:0]     chr;
        logic           trunc;
        logic           last;
    } word_event_t;

    // one line of the stimulus script: a register write or a request
    typedef struct packed {
        logic                    is_cfg;
        logic [1:0]              reg_idx;
        logic [63:0]             value;
        logic [7:0]              chr;
        logic                    le;
        logic                    typed_ok;
        logic [1:0]              n_typed;
        word_event_t [1:0]       typed;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] in_byte
    logic        s_tlast;   // line_end
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] out_byte, [8] truncated, rest zero
    logic [1:0]  m_tuser;   // [1:0] kind
    logic        m_tlast;   // last_of_run
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    quoted_word_tokenizer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state and register shadow
    qwt_pkg::cfg_t shadow;
    scan_t         scan_st;
    logic          bs_held;
    logic [7:0]    word_len;
    logic          dropped;
    word_event_t   step_out [qwt_pkg::MAX_RESULTS];
    int            step_n;

    word_event_t events_due [$];
    row_t        requests_sent [$];
    int          mismatches;
    int          send_idle_pct;
    int          stall_pct;
    int          stall_len;
    int          cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic word_event_t ev(qwt_pkg::kind_t k, logic [7:0] c, logic t, logic l);
        return '{kind: k, chr: c, trunc: t, last: l};
    endfunction

    function automatic row_t row_send(logic [7:0] c, logic l);
        row_t r;
        r = '0;
        r.chr = c;
        r.le = l;
        return r;
    endfunction

    function automatic row_t row_typed(logic [7:0] c, logic l, logic [1:0] n,
                                       word_event_t e0, word_event_t e1);
        row_t r;
        r = row_send(c, l);
        r.typed_ok = 1'b1;
        r.n_typed = n;
        r.typed[0] = e0;
        r.typed[1] = e1;
        return r;
    endfunction

    function automatic row_t row_cfg(logic [1:0] idx, logic [63:0] val);
        row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.value = val;
        return r;
    endfunction

    function automatic void emit(qwt_pkg::kind_t k, logic [7:0] c, logic t);
        if (step_n < qwt_pkg::MAX_RESULTS)
        begin
            step_out[step_n] = ev(k, c, t, 1'b0);
            step_n++;
        end
    endfunction

    function automatic void keep_char(logic [7:0] c);
        if (word_len < shadow.max_chars)
        begin
            emit(qwt_pkg::KIND_CHAR, c, 1'b0);
            word_len = word_len + 8'd1;
        end
        else
            dropped = 1'b1;
    endfunction

    function automatic void clear_scan();
        scan_st = SCAN_GAP;
        bs_held = 1'b0;
        word_len = 8'd0;
        dropped = 1'b0;
    endfunction

    function automatic void close_word();
        emit(qwt_pkg::KIND_END, 8'd0, dropped);
        clear_scan();
    endfunction

    function automatic logic is_blank(logic [7:0] b);
        return b == qwt_pkg::CH_SPACE || b == qwt_pkg::CH_TAB || b == qwt_pkg::CH_NEWLINE;
    endfunction

    // bytes 128 and up never count as tokens
    function automatic logic is_token_byte(logic [7:0] b);
        if (b[7])
            return 1'b0;
        return b[6] ? shadow.mask_high[b[5:0]] : shadow.mask_low[b[5:0]];
    endfunction

    // results for one input byte; updates the scan state
    function automatic void scan_byte(logic [7:0] b, logic le);
        logic in_word;
        logic done;
        step_n = 0;
        done = 1'b0;
        in_word = scan_st == SCAN_WORD || scan_st == SCAN_QUOTED;
        if (le || b == 8'd0)
        begin
            if (in_word)
            begin
                if (bs_held)
                    keep_char(qwt_pkg::CH_BACKSLASH);
                close_word();
            end
            clear_scan();
        end
        else
        begin
            if (in_word && bs_held)
            begin
                bs_held = 1'b0;
                if (b == qwt_pkg::CH_QUOTE)
                begin
                    keep_char(qwt_pkg::CH_QUOTE);
                    done = 1'b1;
                end
                else
                    keep_char(qwt_pkg::CH_BACKSLASH);
            end
            if (!done)
            begin
                case (scan_st)
                    SCAN_WORD:
                    begin
                        if (is_blank(b))
                            close_word();
                        else if (is_token_byte(b))
                        begin
                            close_word();
                            emit(qwt_pkg::KIND_TOKEN, b, 1'b0);
                        end
                        else if (b == qwt_pkg::CH_BACKSLASH)
                            bs_held = 1'b1;
                        else
                            keep_char(b);
                    end
                    SCAN_QUOTED:
                    begin
                        if (b == qwt_pkg::CH_QUOTE)
                            close_word();
                        else if (b == qwt_pkg::CH_BACKSLASH)
                            bs_held = 1'b1;
                        else
                            keep_char(b);
                    end
                    default:
                    begin
                        clear_scan();
                        if (is_blank(b))
                            ;
                        else if (is_token_byte(b))
                            emit(qwt_pkg::KIND_TOKEN, b, 1'b0);
                        else if (b == qwt_pkg::CH_QUOTE)
                            scan_st = SCAN_QUOTED;
                        else
                        begin
                            scan_st = SCAN_WORD;
                            if (b == qwt_pkg::CH_BACKSLASH)
                                bs_held = 1'b1;
                            else
                                keep_char(b);
                        end
                    end
                endcase
            end
        end
        if (step_n > 0)
            step_out[step_n-1].last = 1'b1;
    endfunction

    // request and result handshakes, sampled at the edge
    always @(posedge clk)
    begin
        row_t        req;
        word_event_t exp;
        if (rst_n && s_tvalid && s_tready)
        begin
            req = requests_sent.pop_front();
            scan_byte(req.chr, req.le);
            if (req.typed_ok)
            begin
                for (int i = 0; i < req.n_typed; i++)
                    events_due.push_back(req.typed[i]);
            end
            else
            begin
                for (int i = 0; i < step_n; i++)
                    events_due.push_back(step_out[i]);
            end
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            if (events_due.size() == 0)
            begin
                $error("unexpected result: kind %0d byte %02h trunc %0b last %0b",
                       m_tuser, m_tdata[7:0], m_tdata[8], m_tlast);
                mismatches++;
            end
            else
            begin
                exp = events_due.pop_front();
                if (m_tuser !== exp.kind)
                begin
                    $error("kind: expected %0d, got %0d", exp.kind, m_tuser);
                    mismatches++;
                end
                if (m_tdata[7:0] !== exp.chr)
                begin
                    $error("out_byte: expected %02h, got %02h", exp.chr, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tdata[8] !== exp.trunc)
                begin
                    $error("truncated: expected %0b, got %0b", exp.trunc, m_tdata[8]);
                    mismatches++;
                end
                if (m_tlast !== exp.last)
                begin
                    $error("last_of_run: expected %0b, got %0b", exp.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_len != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall_len) @(posedge clk);
                stall_len = 0;
            end
            m_tready <= $urandom_range(99) >= stall_pct;
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[quoted_word_tokenizer_core] ERROR");
        $finish;
    end

    task automatic send_request(row_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        requests_sent.push_back(r);
        s_tvalid <= 1'b1;
        s_tdata <= r.chr;
        s_tlast <= r.le;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // stop offering and wait for every outstanding result, then let the clock run idle
    task automatic settle();
        s_tvalid <= 1'b0;
        while (requests_sent.size() != 0 || events_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            qwt_pkg::REG_MASK_LOW:  shadow.mask_low = val;
            qwt_pkg::REG_MASK_HIGH: shadow.mask_high = val;
            qwt_pkg::REG_MAX_CHARS: shadow.max_chars = val[7:0];
            default: ;
        endcase
    endtask

    initial
    begin
        row_t        script [$];
        row_t        r;
        word_event_t none;
        logic [63:0] shell_low;
        logic [63:0] shell_high;
        logic [63:0] set_low;
        logic [63:0] set_high;
        logic [7:0]  set_max;
        logic [7:0]  b;
        logic        le;
        int          pick;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        stall_len = 0;
        shadow = '{mask_low: 64'd0, mask_high: 64'd0, max_chars: 8'd255};
        clear_scan();
        none = '0;
        // ; & ( ) < > in the low half, | in the high half
        shell_low = (64'd1 << 8'h3B) | (64'd1 << 8'h26) | (64'd1 << 8'h28)
                  | (64'd1 << 8'h29) | (64'd1 << 8'h3C) | (64'd1 << 8'h3E);
        shell_high = 64'd1 << (8'h7C - 64);

        // line end between words, plain word, high byte, escapes
        script.push_back(row_typed(8'hFF, 1'b1, 2'd0, none, none));
        script.push_back(row_typed("a", 1'b0, 2'd1,
                                   ev(qwt_pkg::KIND_CHAR, "a", 1'b0, 1'b1), none));
        script.push_back(row_typed(8'h00, 1'b0, 2'd1,
                                   ev(qwt_pkg::KIND_END, 8'h00, 1'b0, 1'b1), none));
        script.push_back(row_typed(8'hFF, 1'b0, 2'd1,
                                   ev(qwt_pkg::KIND_CHAR, 8'hFF, 1'b0, 1'b1), none));
        script.push_back(row_send(qwt_pkg::CH_BACKSLASH, 1'b0));
        script.push_back(row_send(qwt_pkg::CH_QUOTE, 1'b0));
        script.push_back(row_send(qwt_pkg::CH_BACKSLASH, 1'b0));
        script.push_back(row_send("x", 1'b0));
        script.push_back(row_send(qwt_pkg::CH_QUOTE, 1'b0));
        script.push_back(row_send(qwt_pkg::CH_SPACE, 1'b0));
        // unterminated quoted word with a held backslash at line end
        script.push_back(row_send(qwt_pkg::CH_QUOTE, 1'b0));
        script.push_back(row_send(qwt_pkg::CH_SPACE, 1'b0));
        script.push_back(row_send(qwt_pkg::CH_BACKSLASH, 1'b0));
        script.push_back(row_send(8'h5A, 1'b1));
        // empty quoted word
        script.push_back(row_send(qwt_pkg::CH_QUOTE, 1'b0));
        script.push_back(row_send(qwt_pkg::CH_QUOTE, 1'b0));
        // token set with the quote in it, limit of two characters
        script.push_back(row_cfg(qwt_pkg::REG_MASK_LOW,
                                 shell_low | (64'd1 << qwt_pkg::CH_QUOTE)));
        script.push_back(row_cfg(qwt_pkg::REG_MASK_HIGH, shell_high));
        script.push_back(row_cfg(qwt_pkg::REG_MAX_CHARS, 64'd2));
        script.push_back(row_send("a", 1'b0));
        script.push_back(row_send("b", 1'b0));
        script.push_back(row_send("c", 1'b0));
        script.push_back(row_send(";", 1'b0));
        script.push_back(row_send(qwt_pkg::CH_QUOTE, 1'b0));
        script.push_back(row_send("|", 1'b0));
        script.push_back(row_send(qwt_pkg::CH_TAB, 1'b0));
        // zero limit drops everything
        script.push_back(row_cfg(qwt_pkg::REG_MAX_CHARS, 64'd0));
        script.push_back(row_send("q", 1'b0));
        script.push_back(row_typed(8'h00, 1'b0, 2'd1,
                                   ev(qwt_pkg::KIND_END, 8'h00, 1'b1, 1'b1), none));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                settle();
                reg_write(script[i].reg_idx, script[i].value);
            end
            else
                send_request(script[i]);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    set_low = {$urandom, $urandom};
                    set_high = {$urandom, $urandom};
                    set_max = 8'($urandom_range(6, 1));
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    set_low = 64'd0;
                    set_high = 64'd0;
                    set_max = 8'd255;
                    send_idle_pct = 62;
                    stall_pct = 0;
                end
                2:
                begin
                    set_low = '1;
                    set_high = '1;
                    set_max = 8'd1;
                    send_idle_pct = 0;
                    stall_pct = 62;
                end
                3:
                begin
                    set_low = shell_low;
                    set_high = shell_high;
                    set_max = 8'd3;
                    send_idle_pct = 23;
                    stall_pct = 23;
                end
                default:
                begin
                    set_low = shell_low | (64'd1 << qwt_pkg::CH_QUOTE);
                    set_high = shell_high;
                    set_max = 8'($urandom_range(255, 4));
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
            endcase
            reg_write(qwt_pkg::REG_MASK_LOW, set_low);
            reg_write(qwt_pkg::REG_MASK_HIGH, set_high);
            reg_write(qwt_pkg::REG_MAX_CHARS, {56'd0, set_max});

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // last phase: long output hold-off to fill the block, later a full pause
                if (ph == 4 && i == 10)
                    stall_len = 60;
                if (ph == 4 && i == 45)
                    settle();
                pick = $urandom_range(99);
                le = 1'b0;
                if (pick < 40)
                    b = 8'($urandom_range(8'h7E, 8'h21));
                else if (pick < 52)
                    b = ($urandom_range(2) == 0) ? qwt_pkg::CH_SPACE
                      : ($urandom_range(1) == 0) ? qwt_pkg::CH_TAB : qwt_pkg::CH_NEWLINE;
                else if (pick < 62)
                    b = qwt_pkg::CH_QUOTE;
                else if (pick < 70)
                    b = qwt_pkg::CH_BACKSLASH;
                else if (pick < 80)
                begin
                    case ($urandom_range(6))
                        0: b = ";";
                        1: b = "|";
                        2: b = "&";
                        3: b = "(";
                        4: b = ")";
                        5: b = "<";
                        default: b = ">";
                    endcase
                end
                else if (pick < 84)
                    b = 8'h00;
                else if (pick < 88)
                begin
                    b = 8'($urandom_range(255));
                    le = 1'b1;
                end
                else
                    b = 8'($urandom_range(255));
                r = row_send(b, le);
                send_request(r);
            end
        end

        settle();
        if (mismatches == 0)
            $display("[quoted_word_tokenizer_core] OK");
        else
            $display("[quoted_word_tokenizer_core] ERROR");
        $finish;
    end

endmodule
